[rtl/tked_pkg.sv]
// ----------------------------------------------------------------------------
// tked_pkg
// types and constants shared by the touch key event detector
// ----------------------------------------------------------------------------
package tked_pkg;

    localparam int RAW_W = 12;
    localparam int MAX_KEYS = 16;

    typedef enum logic [2:0] {
        EV_NONE    = 3'd0,
        EV_TOUCH   = 3'd1,
        EV_RELEASE = 3'd2,
        EV_SHORT   = 3'd3,
        EV_LONG    = 3'd4
    } event_kind_t;

    typedef enum logic [1:0] {
        CFG_DEBOUNCE = 2'd0,
        CFG_SHORT    = 2'd1,
        CFG_LONG     = 2'd2
    } cfg_index_t;

    typedef struct packed {
        logic [11:0] raw_mask;
        logic [31:0] now_ms;
    } poll_t;

    typedef struct packed {
        logic [3:0]  electrode;
        logic [2:0]  event_kind;
        logic [11:0] touched_mask;
        logic        last_of_poll;
    } key_event_t;

    // front-end state machine
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_EMIT
    } scan_state_t;

    // one classified key update, queued to the back end
    typedef struct packed {
        logic [3:0] electrode;
        logic       touch;
        logic       lift;
        logic       tap;
        logic       hold;
        logic       last_key;
    } key_req_t;

endpackage

[rtl/tked_front.sv]
// ----------------------------------------------------------------------------
// tked_front
// scans a key per cycle unless stalled, updates key state, queues key requests
// ----------------------------------------------------------------------------
module tked_front
    import tked_pkg::*;
#(
    parameter int NUM_KEYS = 12
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  poll_t       in_data,
    input  logic [15:0] debounce_time,
    input  logic [15:0] tap_limit,
    input  logic [15:0] hold_limit,
    output logic        q_valid,
    input  logic        q_stall,
    output key_req_t    q_data
);

    localparam int KW = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;

    scan_state_t state_reg, state_next;
    logic [KW-1:0] key_reg, key_next;
    poll_t poll_reg;
    logic [NUM_KEYS-1:0] raw_reg, touched_reg, fired_reg;
    logic [31:0] change_reg [NUM_KEYS];
    logic [31:0] start_reg [NUM_KEYS];

    logic qv_reg;
    key_req_t qd_reg, q_next;
    logic pend_v_reg;
    key_req_t pend_reg, cur_req;

    logic raw_now, deb, last_key;
    logic [3:0] key4;
    logic [31:0] chg, dt_chg, dt_start;
    logic do_touch, do_release, do_short, do_long, any_ev;
    logic step, q_free, q_load, emit_done;

    assign key4 = 4'(key_reg);
    assign raw_now = (key4 < 4'(RAW_W)) ? poll_reg.raw_mask[key4] : 1'b0;
    assign last_key = (key_reg == KW'(NUM_KEYS - 1));
    assign chg = (raw_now != raw_reg[key_reg]) ? poll_reg.now_ms : change_reg[key_reg];
    assign dt_chg = poll_reg.now_ms - chg;
    assign dt_start = poll_reg.now_ms - start_reg[key_reg];
    assign deb = (dt_chg >= {16'd0, debounce_time}) ? raw_now : touched_reg[key_reg];

    always_comb
    begin
        do_touch = deb && !touched_reg[key_reg];
        do_release = !deb && touched_reg[key_reg];
        do_short = do_release && !fired_reg[key_reg]
                   && (dt_start < {16'd0, tap_limit});
        if (do_touch)
            do_long = (hold_limit == 16'd0);
        else
            do_long = touched_reg[key_reg] && !do_release && !fired_reg[key_reg]
                      && (dt_start >= {16'd0, hold_limit});
        any_ev = do_touch || do_release || do_long;
    end

    // the newest event key is held back until the next one or the end of the scan
    assign q_free = !qv_reg || !q_stall;
    assign step = (state_reg == ST_SCAN) && !(any_ev && pend_v_reg && !q_free);
    assign emit_done = (state_reg == ST_EMIT) && q_free;
    assign q_load = (step && any_ev && pend_v_reg) || emit_done;

    always_comb
    begin
        cur_req.electrode = key4;
        cur_req.touch = do_touch;
        cur_req.lift = do_release;
        cur_req.tap = do_short;
        cur_req.hold = do_long;
        cur_req.last_key = 1'b0;
        q_next = pend_reg;
        if (state_reg == ST_EMIT)
        begin
            if (!pend_v_reg)
                q_next = '0;
            q_next.last_key = 1'b1;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        key_next = key_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_SCAN;
                    key_next = '0;
                end
            end
            ST_SCAN:
            begin
                if (step)
                begin
                    if (last_key)
                        state_next = ST_EMIT;
                    else
                        key_next = key_reg + KW'(1);
                end
            end
            ST_EMIT:
            begin
                if (q_free)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign in_stall = (state_reg != ST_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            key_reg <= '0;
            qv_reg <= 1'b0;
            pend_v_reg <= 1'b0;
            raw_reg <= '0;
            touched_reg <= '0;
            fired_reg <= '0;
            for (int i = 0; i < NUM_KEYS; i++)
            begin
                change_reg[i] <= '0;
                start_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            key_reg <= key_next;
            if (q_load)
            begin
                qv_reg <= 1'b1;
                qd_reg <= q_next;
            end
            else if (!q_stall)
                qv_reg <= 1'b0;
            if (state_reg == ST_IDLE && in_valid)
            begin
                poll_reg <= in_data;
                pend_v_reg <= 1'b0;
            end
            else if (step && any_ev)
            begin
                pend_v_reg <= 1'b1;
                pend_reg <= cur_req;
            end
            if (step)
            begin
                raw_reg[key_reg] <= raw_now;
                change_reg[key_reg] <= chg;
                if (do_touch)
                begin
                    touched_reg[key_reg] <= 1'b1;
                    start_reg[key_reg] <= poll_reg.now_ms;
                end
                if (do_release)
                    touched_reg[key_reg] <= 1'b0;
                if (do_touch)
                    fired_reg[key_reg] <= do_long;
                else if (do_long)
                    fired_reg[key_reg] <= 1'b1;
            end
        end
    end

    assign q_valid = qv_reg;
    assign q_data = qd_reg;

`ifndef SYNTH
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> in_stall)
        else $error("accepted poll while busy");
    a_fired_needs_touch: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(fired_reg[0]) |-> touched_reg[0])
        else $error("long press without touch");
    a_queue_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (q_valid && q_stall) |=> q_valid && $stable(q_data))
        else $error("queue request dropped");
`endif

endmodule

[rtl/tked_back.sv]
// ----------------------------------------------------------------------------
// tked_back
// expands key requests into event results and tracks the touched mask
// ----------------------------------------------------------------------------
module tked_back
    import tked_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       q_valid,
    output logic       q_stall,
    input  key_req_t   q_data,
    output logic       out_valid,
    input  logic       out_stall,
    output key_event_t out_data
);

    key_req_t req_reg, req_next;
    logic busy_reg, busy_next;
    logic [11:0] mask_reg, mask_next;
    logic ov_reg;
    key_event_t od_reg;

    key_req_t cur;
    logic emit;
    event_kind_t kind;
    logic has_more;
    logic [11:0] bit_mask;

    assign cur = busy_reg ? req_reg : q_data;
    assign q_stall = busy_reg || (ov_reg && out_stall);
    assign emit = (busy_reg || q_valid) && !(ov_reg && out_stall);
    assign bit_mask = (cur.electrode < 4'(RAW_W)) ? (12'd1 << cur.electrode) : 12'd0;

    always_comb
    begin
        req_next = cur;
        mask_next = mask_reg;
        kind = EV_NONE;
        if (cur.touch)
        begin
            kind = EV_TOUCH;
            req_next.touch = 1'b0;
            mask_next = mask_reg | bit_mask;
        end
        else if (cur.lift)
        begin
            kind = EV_RELEASE;
            req_next.lift = 1'b0;
            mask_next = mask_reg & ~bit_mask;
        end
        else if (cur.tap)
        begin
            kind = EV_SHORT;
            req_next.tap = 1'b0;
        end
        else if (cur.hold)
        begin
            kind = EV_LONG;
            req_next.hold = 1'b0;
        end
        has_more = req_next.touch || req_next.lift || req_next.tap
                   || req_next.hold;
        busy_next = emit ? has_more : busy_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            mask_reg <= '0;
            ov_reg <= 1'b0;
        end
        else
        begin
            if (emit)
                ov_reg <= 1'b1;
            else if (!out_stall)
                ov_reg <= 1'b0;
            if (emit)
            begin
                busy_reg <= busy_next;
                req_reg <= req_next;
                mask_reg <= mask_next;
                od_reg.electrode <= cur.electrode;
                od_reg.event_kind <= kind;
                od_reg.touched_mask <= mask_next;
                od_reg.last_of_poll <= cur.last_key && !has_more;
            end
        end
    end

    assign out_valid = ov_reg;
    assign out_data = od_reg;

`ifndef SYNTH
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> out_valid && $stable(out_data))
        else $error("result dropped under stall");
    a_busy_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> q_stall)
        else $error("queue read while expanding");
    a_kind_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_data.event_kind <= 3'd4)
        else $error("bad event code");
`endif

endmodule

[rtl/touch_key_event_detector.sv]
// ----------------------------------------------------------------------------
// touch_key_event_detector
// debounced touch, release, short click and long press events per electrode
// ----------------------------------------------------------------------------
// A poll (raw_mask, now_ms) enters on the input channel (valid/stall). The
// front end visits one electrode per cycle while not paused by a full queue,
// then closes the poll in its emit state; a new poll is taken only once the
// front end is back in idle. An event key's request is held until the next
// event key or the end of the scan, then passes through a one-entry queue to
// the back end, which gives one result per cycle while the receiver does not
// stall: touch, release, short click, long press, each carrying the touched
// mask after the event. A poll without events gives one result of kind none
// for electrode 0. The final result of a poll has last_of_poll set. When the
// receiver stalls, the result register holds, the back end stops taking
// requests and the scan pauses at an event key while the queue is full.
// Reset clears all key state and loads registers to 20, 300 and 1000 ms.
// Register writes (cfg_we, cfg_index, cfg_data) are for the user to make
// only while idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module touch_key_event_detector
    import tked_pkg::*;
#(
    parameter int NUM_KEYS = 12
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  poll_t       in_data,
    output logic        out_valid,
    input  logic        out_stall,
    output key_event_t  out_data,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    logic [15:0] debounce_reg, short_reg, long_reg;
    logic q_valid, q_stall;
    key_req_t q_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            debounce_reg <= 16'd20;
            short_reg <= 16'd300;
            long_reg <= 16'd1000;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_DEBOUNCE: debounce_reg <= cfg_data;
                CFG_SHORT:    short_reg <= cfg_data;
                CFG_LONG:     long_reg <= cfg_data;
                default:      ;
            endcase
        end
    end

    tked_front #(.NUM_KEYS(NUM_KEYS)) u_front (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
        .debounce_time(debounce_reg), .tap_limit(short_reg),
        .hold_limit(long_reg),
        .q_valid(q_valid), .q_stall(q_stall), .q_data(q_data)
    );

    tked_back u_back (
        .clk(clk), .rst_n(rst_n),
        .q_valid(q_valid), .q_stall(q_stall), .q_data(q_data),
        .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
    );

endmodule

[dv/tked_checker.sv]
// ----------------------------------------------------------------------------
// tked_checker
// predicts and checks the event stream of the touch key event detector
// ----------------------------------------------------------------------------
// Watches the poll, event and register ports. Each accepted poll runs through
// a per-electrode debounce, click and long press predictor. The events it
// gives are queued, and each accepted event is compared field by field with
// the oldest one in the queue.
// ----------------------------------------------------------------------------
module tked_checker
    import tked_pkg::*;
#(
    parameter int NUM_KEYS = 12
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_stall,
    input  poll_t       in_data,
    input  logic        out_valid,
    input  logic        out_stall,
    input  key_event_t  out_data,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,
    output int          fail_count,
    output int          pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_EVENTS = 24;

    logic [15:0] debounce_ms;
    logic [15:0] short_ms;
    logic [15:0] long_ms;
    logic        raw_lvl [NUM_KEYS];
    logic [31:0] change_t [NUM_KEYS];
    logic        held_down [NUM_KEYS];
    logic        long_done [NUM_KEYS];
    logic [31:0] press_t [NUM_KEYS];
    logic [11:0] down_mask;
    key_event_t  event_q [$];

    function automatic void push_event(int first, int key, event_kind_t kind);
        key_event_t ev;
        if (event_q.size() - first >= MAX_EVENTS)
            return;
        ev.electrode = key[3:0];
        ev.event_kind = kind;
        ev.touched_mask = down_mask;
        ev.last_of_poll = 1'b0;
        event_q.push_back(ev);
    endfunction

    function automatic void predict_poll(poll_t p);
        int          first;
        logic        raw_now;
        logic        deb;
        logic [11:0] bit_k;
        logic [31:0] held;
        first = event_q.size();
        for (int k = 0; k < NUM_KEYS; k++)
        begin
            raw_now = (k < 12) ? p.raw_mask[k] : 1'b0;
            bit_k = (k < 12) ? (12'd1 << k) : 12'd0;
            if (raw_now != raw_lvl[k])
            begin
                raw_lvl[k] = raw_now;
                change_t[k] = p.now_ms;
            end
            deb = held_down[k];
            if (p.now_ms - change_t[k] >= {16'd0, debounce_ms})
                deb = raw_lvl[k];
            if (deb && !held_down[k])
            begin
                held_down[k] = 1'b1;
                long_done[k] = 1'b0;
                press_t[k] = p.now_ms;
                down_mask = down_mask | bit_k;
                push_event(first, k, EV_TOUCH);
            end
            if (!deb && held_down[k])
            begin
                held = p.now_ms - press_t[k];
                held_down[k] = 1'b0;
                down_mask = down_mask & ~bit_k;
                push_event(first, k, EV_RELEASE);
                if (!long_done[k] && held < {16'd0, short_ms})
                    push_event(first, k, EV_SHORT);
            end
            if (held_down[k] && !long_done[k] && p.now_ms - press_t[k] >= {16'd0, long_ms})
            begin
                long_done[k] = 1'b1;
                push_event(first, k, EV_LONG);
            end
        end
        if (event_q.size() == first)
            push_event(first, 0, EV_NONE);
        event_q[event_q.size() - 1].last_of_poll = 1'b1;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        key_event_t exp_ev;
        if (!rst_n)
        begin
            debounce_ms <= 16'd20;
            short_ms <= 16'd300;
            long_ms <= 16'd1000;
            for (int k = 0; k < NUM_KEYS; k++)
            begin
                raw_lvl[k] = 1'b0;
                change_t[k] = '0;
                held_down[k] = 1'b0;
                long_done[k] = 1'b0;
                press_t[k] = '0;
            end
            down_mask = '0;
            event_q.delete();
            fail_count = 0;
            pending = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_DEBOUNCE: debounce_ms <= cfg_data;
                    CFG_SHORT:    short_ms <= cfg_data;
                    CFG_LONG:     long_ms <= cfg_data;
                    default:      ;
                endcase
            end
            if (in_valid && !in_stall)
                predict_poll(in_data);
            if (out_valid && !out_stall)
            begin
                if (event_q.size() == 0)
                begin
                    $error("event with nothing expected: %p", out_data);
                    fail_count++;
                end
                else
                begin
                    exp_ev = event_q.pop_front();
                    if (out_data.electrode !== exp_ev.electrode)
                    begin
                        $error("electrode expected %0d actual %0d",
                               exp_ev.electrode, out_data.electrode);
                        fail_count++;
                    end
                    if (out_data.event_kind !== exp_ev.event_kind)
                    begin
                        $error("event_kind expected %0d actual %0d",
                               exp_ev.event_kind, out_data.event_kind);
                        fail_count++;
                    end
                    if (out_data.touched_mask !== exp_ev.touched_mask)
                    begin
                        $error("touched_mask expected %h actual %h",
                               exp_ev.touched_mask, out_data.touched_mask);
                        fail_count++;
                    end
                    if (out_data.last_of_poll !== exp_ev.last_of_poll)
                    begin
                        $error("last_of_poll expected %0d actual %0d",
                               exp_ev.last_of_poll, out_data.last_of_poll);
                        fail_count++;
                    end
                end
            end
            pending = event_q.size();
        end
    end

endmodule

[dv/tb.sv]
// ----------------------------------------------------------------------------
// tb
// stimulus and verdict for the touch key event detector
// ----------------------------------------------------------------------------
// Sends directed polls covering touch, release, short click, long press,
// zero and maximum times, timestamp wrap and all-electrode polls, then
// random poll sequences under several register settings, with random gaps
// and result stalls. The checker beside the block does the comparison.
// ----------------------------------------------------------------------------
module tb;
    import tked_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] CFG_UNUSED = 2'd3;
    localparam int PHASE_POLLS = 56;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    poll_t       in_data = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    key_event_t  out_data;
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_index = CFG_DEBOUNCE;
    logic [15:0] cfg_data = '0;
    int          fail_count;
    int          pending;
    logic        no_gaps = 1'b0;
    logic [31:0] clock_ms = '0;
    logic [11:0] raw_now = '0;

    touch_key_event_detector i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    tked_checker i_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_data    (in_data),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_data   (out_data),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    always @(negedge clk)
        out_stall <= !no_gaps && ($urandom_range(0, 99) < 7);

    task automatic send_poll(logic [11:0] raw, logic [31:0] now);
        @(negedge clk);
        while (!no_gaps && $urandom_range(0, 99) < 7)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data <= '{raw_mask: raw, now_ms: now};
        while (in_stall)
            @(negedge clk);
        @(posedge clk);
        @(negedge clk);
        in_valid <= 1'b0;
    endtask

    task automatic settle();
        wait (pending == 0);
        repeat (30) @(negedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [15:0] val);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic set_times(logic [15:0] deb, logic [15:0] shrt, logic [15:0] lng);
        settle();
        write_reg(CFG_DEBOUNCE, deb);
        write_reg(CFG_SHORT, shrt);
        write_reg(CFG_LONG, lng);
    endtask

    task automatic random_polls(int n);
        int r;
        for (int i = 0; i < n; i++)
        begin
            r = $urandom_range(0, 99);
            if (r < 10)
                raw_now = 12'($urandom);
            else if (r < 60)
                raw_now[$urandom_range(0, 11)] ^= 1'b1;
            r = $urandom_range(0, 99);
            if (r < 70)
                clock_ms += $urandom_range(0, 60);
            else if (r < 92)
                clock_ms += $urandom_range(0, 1500);
            else
                clock_ms = $urandom;
            send_poll(raw_now, clock_ms);
        end
    endtask

    initial
    begin
        #5_000_000;
        $display("Verification failed");
        $finish;
    end

    initial
    begin
        repeat (2) @(negedge clk);
        rst_n <= 1'b1;

        // reset times: 20 / 300 / 1000
        send_poll(12'h000, 32'd0);
        send_poll(12'hFFF, 32'd100);
        send_poll(12'hFFF, 32'd120);
        send_poll(12'hFFF, 32'd1120);
        send_poll(12'h000, 32'd1130);
        send_poll(12'h000, 32'd1150);
        send_poll(12'h001, 32'd1200);
        send_poll(12'h001, 32'd1220);
        send_poll(12'h000, 32'd1300);
        send_poll(12'h000, 32'd1320);

        // zero debounce and zero long press
        set_times(16'd0, 16'hFFFF, 16'd0);
        send_poll(12'h801, 32'd2000);
        send_poll(12'h000, 32'd2001);
        settle();
        write_reg(CFG_UNUSED, 16'd5);
        write_reg(CFG_LONG, 16'hFFFF);
        send_poll(12'h002, 32'd3000);
        send_poll(12'h000, 32'd3001);

        // timestamp wrap
        set_times(16'd20, 16'd300, 16'd1000);
        send_poll(12'h004, 32'hFFFF_FFF0);
        send_poll(12'h004, 32'h0000_0010);
        send_poll(12'h004, 32'h0000_0400);
        send_poll(12'h000, 32'h0000_0410);
        send_poll(12'h000, 32'h0000_0430);
        clock_ms = 32'h0000_0430;

        random_polls(PHASE_POLLS);
        set_times(16'd0, 16'd0, 16'd0);
        random_polls(PHASE_POLLS);
        set_times(16'hFFFF, 16'hFFFF, 16'hFFFF);
        no_gaps <= 1'b1;
        random_polls(PHASE_POLLS);
        no_gaps <= 1'b0;
        set_times(16'd5, 16'd200, 16'd400);
        random_polls(PHASE_POLLS);
        set_times(16'd0, 16'hFFFF, 16'd50);
        random_polls(PHASE_POLLS);

        wait (pending == 0);
        repeat (30) @(negedge clk);
        if (fail_count == 0 && pending == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
